/* hdl/assert_macros.svh */
// assertion macros shared by the srfd modules
// expects clk and arst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SRFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SRFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/srfd_pkg.sv */
// types and constants of the subpicture run-length field decoder
// no dependencies
`default_nettype none

package srfd_pkg;

	localparam int MAX_WIDTH_DEF   = 4096;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int LINE_WIDTH_W = 13;
	localparam int HEIGHT_W     = 13;
	localparam int MAP_W        = 16;
	localparam int ROW_W        = 12;
	localparam int COLUMN_W     = 12;
	localparam int RUN_LEN_W    = 13;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET   = 13'd720;
	localparam logic [HEIGHT_W-1:0]     IMAGE_HEIGHT_RESET = 13'd576;

	// code length thresholds and fill limit
	localparam logic [15:0] CODE_MIN_1 = 16'h0004;
	localparam logic [15:0] CODE_MIN_2 = 16'h0010;
	localparam logic [15:0] CODE_MIN_3 = 16'h0040;
	localparam logic [15:0] FILL_LIMIT = 16'h0100;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LINE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_FIELD_SELECT = 3'd2,
		REG_COLOR_MAP    = 3'd3,
		REG_ALPHA_MAP    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [LINE_WIDTH_W-1:0] line_width;
		logic [HEIGHT_W-1:0]     image_height;
		logic                    field_select;
		logic [MAP_W-1:0]        color_map;
		logic [MAP_W-1:0]        alpha_map;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]     row;
		logic [COLUMN_W-1:0]  column;
		logic [RUN_LEN_W-1:0] run_len;
		logic [3:0]           pixel_color;
		logic [3:0]           pixel_alpha;
		logic                 partial_row;
		logic                 pass_end;
		logic                 last;
	} run_item_t;

	// decoded run waiting for color and alpha lookup
	typedef struct packed {
		logic [ROW_W-1:0]     row;
		logic [COLUMN_W-1:0]  column;
		logic [RUN_LEN_W-1:0] run_len;
		logic [1:0]           code_low;
		logic                 marker;
		logic                 partial_row;
		logic                 pass_end;
		logic                 last;
	} run_rec_t;

	typedef struct packed {
		logic [1:0] count;
		run_rec_t   rec1;
		run_rec_t   rec0;
	} push_t;

endpackage

`default_nettype wire

/* hdl/srfd_stream_if.sv */
// valid/ready channel carrying one payload per request
// payload type is set where the channel is instantiated
`default_nettype none

interface srfd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/subpicture_rle_field_decoder.sv */
// top level of the subpicture run-length field decoder
// depends on srfd_pkg, srfd_stream_if, srfd_front, srfd_queue and srfd_back
// The decoder takes one coded byte per cycle on byte_stream and emits one run per cycle on
// run_stream while run_stream.ready is high. Each byte is decoded in the cycle it is accepted:
// its two nibbles feed the code gatherer, and the resulting runs (none, one or two) go into a
// queue of QUEUE_DEPTH entries. Runs reach run_stream through the queue and the back end output
// register. A byte that yields two runs sends both through the single output port, so the
// sustained rate is one byte per cycle for bytes with at most one run and one run per cycle
// otherwise; byte_stream.ready drops while fewer than two queue slots are free. Configuration
// writes are taken at any time but must only be issued while no run is in flight.
`default_nettype none

module subpicture_rle_field_decoder #(
	parameter int MAX_WIDTH   = srfd_pkg::MAX_WIDTH_DEF,
	parameter int QUEUE_DEPTH = srfd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	srfd_stream_if.sink                         byte_stream,
	srfd_stream_if.source                       run_stream,
	input  wire logic                           cfg_write,
	input  wire logic [srfd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [srfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import srfd_pkg::*;

	cfg_t     cfg_q;
	push_t    push;
	logic     room;
	logic     not_empty;
	logic     pop;
	run_rec_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_width <= LINE_WIDTH_RESET;
			cfg_q.image_height <= IMAGE_HEIGHT_RESET;
			cfg_q.field_select <= 1'b0;
			cfg_q.color_map <= '0;
			cfg_q.alpha_map <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LINE_WIDTH:   cfg_q.line_width <= cfg_data[LINE_WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[HEIGHT_W-1:0];
				REG_FIELD_SELECT: cfg_q.field_select <= cfg_data[0];
				REG_COLOR_MAP:    cfg_q.color_map <= cfg_data[MAP_W-1:0];
				REG_ALPHA_MAP:    cfg_q.alpha_map <= cfg_data[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	srfd_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_stream(byte_stream),
		.cfg(cfg_q),
		.room(room),
		.push(push)
	);

	srfd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(pop),
		.room(room),
		.not_empty(not_empty),
		.head(head)
	);

	srfd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.not_empty(not_empty),
		.head(head),
		.pop(pop),
		.run_stream(run_stream)
	);

endmodule

`default_nettype wire

/* hdl/srfd_front.sv */
// front end: takes coded bytes, gathers nibble codes, tracks line position
// depends on srfd_pkg and srfd_stream_if; pushes up to two runs per byte
`default_nettype none
`include "assert_macros.svh"

module srfd_front #(
	parameter int MAX_WIDTH = srfd_pkg::MAX_WIDTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	srfd_stream_if.sink         byte_stream,
	input  wire srfd_pkg::cfg_t cfg,
	input  wire logic           room,
	output srfd_pkg::push_t     push
);
	import srfd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LW = CW + 1;
	localparam logic [LINE_WIDTH_W-1:0] MAXW_L = LINE_WIDTH_W'(MAX_WIDTH);

	typedef struct packed {
		logic [CW-1:0]    col;
		logic [ROW_W-1:0] row;
		logic [15:0]      accum;
		logic [1:0]       held;
	} dec_st_t;

	typedef struct packed {
		dec_st_t  st;
		logic     stop_rows;
		logic     emit;
		logic     line_end;
		logic     rows_done;
		run_rec_t rec;
	} step_t;

	function automatic step_t nib_step(input dec_st_t st, input logic [3:0] nib,
			input logic [LW-1:0] w, input logic [ROW_W-1:0] rows, input logic fsel);
		step_t            r;
		logic [15:0]      a;
		logic             done;
		logic             fill;
		logic [LW-1:0]    col_x;
		logic [LW-1:0]    remain;
		logic [13:0]      code_run;
		logic [LW-1:0]    run;
		logic [LW-1:0]    col_sum;
		logic [ROW_W-1:0] row_nx;
		r = '0;
		r.st = st;
		a = {st.accum[11:0], nib};
		unique case (st.held)
			2'd0: done = a >= CODE_MIN_1;
			2'd1: done = a >= CODE_MIN_2;
			2'd2: done = a >= CODE_MIN_3;
			default: done = 1'b1;
		endcase
		fill = (st.held == 2'd3) && (a < FILL_LIMIT);
		col_x = LW'(st.col);
		// width lowered mid-line: one pixel closes the line
		remain = (col_x < w) ? (w - col_x) : LW'(1);
		code_run = a[15:2];
		if (fill || (code_run == '0) || (code_run > 14'(remain))) begin
			run = remain;
		end else begin
			run = LW'(code_run);
		end
		col_sum = col_x + run;
		row_nx = st.row + ROW_W'(1);
		r.stop_rows = (st.held == 2'd0) && (st.row >= rows);
		if (r.stop_rows) begin
			r.emit = 1'b0;
		end else if (!done) begin
			r.st.accum = a;
			r.st.held = st.held + 2'd1;
		end else begin
			r.emit = 1'b1;
			r.rec.row = {st.row[ROW_W-2:0], fsel};
			r.rec.column = COLUMN_W'(st.col);
			r.rec.run_len = RUN_LEN_W'(run);
			r.rec.code_low = a[1:0];
			r.rec.partial_row = run != w;
			r.st.accum = '0;
			r.st.held = 2'd0;
			r.line_end = col_sum >= w;
			if (r.line_end) begin
				r.st.col = '0;
				r.st.row = row_nx;
				r.rows_done = row_nx >= rows;
			end else begin
				r.st.col = CW'(col_sum);
			end
		end
		return r;
	endfunction

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [15:0]      accum_q;
	logic [1:0]       held_q;
	logic             pass_done_q;

	logic             accept;
	logic [LW-1:0]    w;
	logic [ROW_W-1:0] rows;
	dec_st_t          base;
	dec_st_t          fin;
	logic             pd0;
	step_t            s0;
	step_t            s1;
	logic             cont;
	logic             emit0;
	logic             emit1;
	logic             ended;
	run_rec_t         marker;

	assign accept = byte_stream.valid && byte_stream.ready;
	assign byte_stream.ready = room;
	assign rows = cfg.image_height[HEIGHT_W-1:1];

	always_comb begin
		priority if (cfg.line_width == '0) begin
			w = LW'(1);
		end else if (cfg.line_width > MAXW_L) begin
			w = LW'(MAX_WIDTH);
		end else begin
			w = LW'(cfg.line_width);
		end
	end

	always_comb begin
		if (byte_stream.payload.first_byte) begin
			base = '0;
			pd0 = 1'b0;
		end else begin
			base = '{col: col_q, row: row_q, accum: accum_q, held: held_q};
			pd0 = pass_done_q;
		end
		s0 = nib_step(base, byte_stream.payload.data_byte[7:4], w, rows, cfg.field_select);
		// a line end drops the low nibble, as does a code closing in the last byte
		cont = !pd0 && !s0.stop_rows
			&& !(s0.emit && (s0.line_end || byte_stream.payload.last_byte));
		s1 = nib_step(s0.st, byte_stream.payload.data_byte[3:0], w, rows, cfg.field_select);
		emit0 = !pd0 && s0.emit;
		emit1 = cont && s1.emit;
		ended = !pd0 && (s0.stop_rows || s0.rows_done
			|| (cont && (s1.stop_rows || s1.rows_done)) || byte_stream.payload.last_byte);

		if (pd0) begin
			fin = base;
		end else if (cont) begin
			fin = s1.st;
		end else begin
			fin = s0.st;
		end
		if (ended) begin
			fin.accum = '0;
			fin.held = 2'd0;
		end

		marker = '0;
		marker.row = {fin.row[ROW_W-2:0], cfg.field_select};
		marker.column = COLUMN_W'(fin.col);
		marker.marker = 1'b1;
		marker.pass_end = 1'b1;
		marker.last = 1'b1;

		push = '0;
		push.rec1 = s1.rec;
		priority if (emit0) begin
			push.rec0 = s0.rec;
		end else if (emit1) begin
			push.rec0 = s1.rec;
		end else begin
			push.rec0 = marker;
		end
		if (emit0 && emit1) begin
			push.rec1.pass_end = ended;
			push.rec1.last = 1'b1;
			push.count = accept ? 2'd2 : 2'd0;
		end else if (emit0 || emit1) begin
			push.rec0.pass_end = ended;
			push.rec0.last = 1'b1;
			push.count = accept ? 2'd1 : 2'd0;
		end else begin
			push.count = (accept && ended) ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			accum_q <= '0;
			held_q <= 2'd0;
			pass_done_q <= 1'b0;
		end else if (accept) begin
			col_q <= fin.col;
			row_q <= fin.row;
			accum_q <= fin.accum;
			held_q <= fin.held;
			pass_done_q <= pd0 || ended;
		end
	end

	`SRFD_ASSERT(a_end_clears_code, pass_done_q |-> (held_q == 2'd0) && (accum_q == '0), "code kept after pass end")
	`SRFD_ASSERT(a_quiet_after_end, (accept && pass_done_q && !byte_stream.payload.first_byte) |-> (push.count == 2'd0), "run pushed after pass end")

endmodule

`default_nettype wire

/* hdl/srfd_queue.sv */
// short run queue between front and back end, two writes and one read a cycle
// depends on srfd_pkg
`default_nettype none
`include "assert_macros.svh"

module srfd_queue #(
	parameter int DEPTH = srfd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire srfd_pkg::push_t   push,
	input  wire logic              pop,
	output logic                   room,
	output logic                   not_empty,
	output srfd_pkg::run_rec_t     head
);
	import srfd_pkg::*;

	localparam int PW   = $clog2(DEPTH);
	localparam int CNTW = PW + 1;

	run_rec_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;

	// two free slots so a two-run byte always fits
	assign room = count_q <= CNTW'(DEPTH - 2);
	assign not_empty = count_q != '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.rec0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + PW'(1)] <= push.rec1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.count);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q <= count_q + CNTW'(push.count) - CNTW'(pop);
		end
	end

	`SRFD_ASSERT(a_q_bound, count_q <= CNTW'(DEPTH), "queue count beyond depth")
	`SRFD_ASSERT(a_q_no_underrun, pop |-> (count_q != '0), "pop from empty queue")
	`SRFD_ASSERT_NEXT(a_q_pair_lands, (push.count == 2'd2) && !pop, count_q >= CNTW'(2), "run pair lost in queue")

endmodule

`default_nettype wire

/* hdl/srfd_back.sv */
// back end: maps the code index through color and alpha maps into the output register
// depends on srfd_pkg and srfd_stream_if
`default_nettype none
`include "assert_macros.svh"

module srfd_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire srfd_pkg::cfg_t     cfg,
	input  wire logic               not_empty,
	input  wire srfd_pkg::run_rec_t head,
	output logic                    pop,
	srfd_stream_if.source           run_stream
);
	import srfd_pkg::*;

	logic      valid_q;
	run_item_t result_q;
	run_item_t result_d;

	assign pop = not_empty && (!valid_q || run_stream.ready);
	assign run_stream.valid = valid_q;
	assign run_stream.payload = result_q;

	always_comb begin
		result_d.row = head.row;
		result_d.column = head.column;
		result_d.run_len = head.run_len;
		result_d.partial_row = head.partial_row;
		result_d.pass_end = head.pass_end;
		result_d.last = head.last;
		// entry 0 sits in the bottom nibble, and index 0 comes from code bits 00
		if (head.marker) begin
			result_d.pixel_color = 4'd0;
			result_d.pixel_alpha = 4'd0;
		end else begin
			result_d.pixel_color = cfg.color_map[{head.code_low, 2'b00} +: 4];
			result_d.pixel_alpha = cfg.alpha_map[{head.code_low, 2'b00} +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (run_stream.ready) begin
			valid_q <= 1'b0;
		end
	end

	`SRFD_ASSERT(a_marker_closes, (valid_q && (result_q.run_len == '0)) |-> (result_q.pass_end && result_q.last), "empty run that does not end the pass")

endmodule

`default_nettype wire
